FILE: design/gis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gis_pkg: shared types and constants
// Constants for the Park-Miller generator and the fixed-point log unit.
// ----------------------------------------------------------------------------
package gis_pkg;
	localparam int MEAN_W = 16;
	localparam int IVL_W = 21;
	localparam int GEN_W = 31;
	localparam logic [IVL_W-1:0] IVL_MAX = 21'h1FFFFF;
	localparam logic [GEN_W-1:0] PM_M = 31'h7FFFFFFF;
	localparam logic [14:0] PM_A = 15'd16807;
	localparam logic [16:0] PM_Q = 17'd127773;
	localparam logic [11:0] PM_R = 12'd2836;
	localparam logic [1:0] REG_SEED = 2'd0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG_N,
		ST_LOG_N1,
		ST_LOG_M,
		ST_ADV_DIV,
		ST_ADV_MUL,
		ST_LOG_X,
		ST_DIVIDE,
		ST_DECIDE,
		ST_OUT
	} gis_state_t;

	// Control between the sequencer and the log unit.
	typedef struct packed {
		logic       start;
		logic [31:0] value;
	} gis_log_req_t;
endpackage
`default_nettype wire

FILE: design/gis_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gis_if: valid/ready channel
// Carries one payload word with valid and ready.
// ----------------------------------------------------------------------------
interface gis_if #(parameter int W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/gis_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gis_log2: iterative fixed-point log2
// Finds the leading one, then squares the mantissa once per cycle, one
// fraction bit per cycle. done rises as the last bit is stored.
// ----------------------------------------------------------------------------
module gis_log2 #(
	parameter int FRAC = 26
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire gis_pkg::gis_log_req_t req,
	output logic                      done,
	output logic [FRAC+5:0]           result
);
	import gis_pkg::*;

	localparam int CW = $clog2(FRAC + 1);

	logic [32:0]   y_q;
	logic [FRAC-1:0] frac_q;
	logic [4:0]    e_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [4:0]    e_c;
	logic [31:0]   v_c;
	logic [65:0]   sq;
	logic [34:0]   ys;

	always_comb begin
		v_c = (req.value == 32'd0) ? 32'd1 : req.value;
		e_c = 5'd0;
		for (int i = 0; i < 32; i++)
			if (v_c[i]) e_c = 5'(i);
	end

	assign sq = y_q * y_q;
	assign ys = sq[65:31];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			e_q    <= e_c;
			y_q    <= 33'({1'b0, v_c} << (5'd31 - e_c));
			frac_q <= '0;
		end else if (busy_q) begin
			frac_q <= {frac_q[FRAC-2:0], |ys[34:32]};
			y_q    <= (|ys[34:32]) ? ys[33:1] : ys[32:0];
		end
	end

	assign done   = done_q;
	assign result = {1'b0, e_q, frac_q};
endmodule
`default_nettype wire

FILE: design/gis_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gis_div: restoring divider
// Unsigned division, one quotient bit per cycle. done rises as the last
// quotient bit is stored.
// ----------------------------------------------------------------------------
module gis_div #(
	parameter int W = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          start,
	input  wire  [W-1:0] dividend,
	input  wire  [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient
);
	import gis_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  q_q;
	logic [W-1:0]  d_q;
	logic [W:0]    r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    trial;

	assign trial = {r_q[W-1:0], q_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			d_q <= divisor;
			r_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;
endmodule
`default_nettype wire

FILE: design/geometric_interval_sampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// geometric_interval_sampler: geometric random interval generator
// Draws Park-Miller values and turns them into geometric intervals.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload          Handshake
// req_ch    in   mean_interval    valid/ready
// rsp_ch    out  interval         valid/ready
// apb       in   seed_value       psel/penable/pwrite
//
// A request with mean N >= 2 is accepted, then the log unit takes the log2
// of N, N-1 and 2^31-1 in turn. Each draw then updates the generator
// (ADV_DIV, ADV_MUL), takes the log of the draw, divides when the ratio
// is needed, and ends in a decision state; the logs use the one log unit
// and the division the one divider. A request with N <= 1 skips the logs
// and the division and gives an interval of 1. A redraw repeats the draw.
// The block takes no new request until the result has been taken. Reset
// loads the seed of 1.
module geometric_interval_sampler #(
	parameter int LOG_FRAC_BITS = 26
) (
	input  wire         clk,
	input  wire         arst_n,
	gis_if.sink         req_ch,
	gis_if.source       rsp_ch,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [1:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gis_pkg::*;

	localparam int LW = LOG_FRAC_BITS + 6;
	localparam int DW = LW;

	gis_state_t  state_q, state_d;
	logic [GEN_W-1:0] seed_q, gen_q;
	logic [GEN_W+14:0] prod_q;
	logic [MEAN_W-1:0] n_q;
	logic [IVL_W-1:0] prev_q, cand_q;
	logic have_prev_q;
	logic [LW-1:0] lm_q, ln_q, ln1_q, lx_q, lx_c;
	logic [LW:0] den_c, num_c;
	logic small_n;
	logic log_busy_q, div_busy_q;
	gis_log_req_t log_req;
	logic log_done, div_done, div_start;
	logic [LW-1:0] log_res;
	logic [DW-1:0] quot;
	logic cfg_wr;
	logic [31:0] fold_c;
	logic [GEN_W-1:0] gen_next_c;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_SEED);
	assign prdata = (paddr == REG_SEED) ? {1'b0, seed_q} : 32'd0;

	assign small_n = (n_q <= 16'd1);
	// The log of the draw is used the cycle it arrives.
	assign lx_c    = (state_q == ST_LOG_X && log_done) ? log_res : lx_q;
	assign den_c   = {1'b0, ln_q} - {1'b0, ln1_q};
	assign num_c   = {1'b0, lm_q} - {1'b0, lx_c};

	// Log unit operand follows the state that starts it.
	always_comb begin
		log_req.start = 1'b0;
		log_req.value = 32'd0;
		if (!log_busy_q) begin
			unique case (state_q)
				ST_LOG_N: begin
					log_req.start = !small_n;
					log_req.value = {16'd0, n_q};
				end
				ST_LOG_N1: begin
					log_req.start = 1'b1;
					log_req.value = {16'd0, n_q - 16'd1};
				end
				ST_LOG_M: begin
					log_req.start = 1'b1;
					log_req.value = {1'b0, PM_M};
				end
				ST_LOG_X: begin
					log_req.start = 1'b1;
					log_req.value = {1'b0, gen_q};
				end
				default: ;
			endcase
		end
	end

	assign div_start = (state_q == ST_DIVIDE) && !div_busy_q;

	gis_log2 #(.FRAC(LOG_FRAC_BITS)) u_log (
		.clk(clk), .arst_n(arst_n), .req(log_req), .done(log_done), .result(log_res));

	gis_div #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(num_c[LW-1:0]), .divisor(den_c[LW-1:0]),
		.done(div_done), .quotient(quot));

	// 16807*x is folded modulo 2^31-1 since 2^31 is congruent to 1. The
	// second fold cannot carry again. A value of zero cannot appear, and a
	// multiple of the modulus stays at 2^31-1 just as Schrage's form does.
	assign fold_c     = {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
	assign gen_next_c = fold_c[30:0] + {30'd0, fold_c[31]};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (req_ch.valid) state_d = ST_LOG_N;
			ST_LOG_N:   if (small_n) state_d = ST_ADV_DIV;
				else if (log_done) state_d = ST_LOG_N1;
			ST_LOG_N1:  if (log_done) state_d = ST_LOG_M;
			ST_LOG_M:   if (log_done) state_d = ST_ADV_DIV;
			ST_ADV_DIV: state_d = ST_ADV_MUL;
			ST_ADV_MUL: state_d = small_n ? ST_DECIDE : ST_LOG_X;
			ST_LOG_X:   if (log_done) begin
				if (num_c[LW] || num_c[LW-1:0] == '0 || den_c[LW] ||
					den_c[LW-1:0] == '0) state_d = ST_DECIDE;
				else state_d = ST_DIVIDE;
			end
			ST_DIVIDE:  if (div_done) state_d = ST_DECIDE;
			ST_DECIDE:  state_d = ST_OUT;
			ST_OUT:     if (rsp_ch.ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
		if (state_q == ST_DECIDE && have_prev_q && cand_q == prev_q + 1'b1)
			state_d = ST_ADV_DIV;
	end

	// Outputs.
	always_comb begin
		req_ch.ready = (state_q == ST_IDLE);
		rsp_ch.valid = (state_q == ST_OUT);
		rsp_ch.data  = cand_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seed_q      <= 31'd1;
			gen_q       <= 31'd1;
			prev_q      <= '0;
			have_prev_q <= 1'b0;
			log_busy_q  <= 1'b0;
			div_busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			log_busy_q <= log_req.start ? 1'b1 : (log_done ? 1'b0 : log_busy_q);
			div_busy_q <= div_start ? 1'b1 : (div_done ? 1'b0 : div_busy_q);
			if (cfg_wr) begin
				seed_q <= pwdata[30:0];
				gen_q  <= (pwdata[30:0] == '0) ? 31'd1 : pwdata[30:0];
			end else if (state_q == ST_ADV_MUL) begin
				gen_q <= gen_next_c;
			end
			if (state_q == ST_DECIDE && state_d == ST_OUT) begin
				prev_q      <= cand_q;
				have_prev_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_ch.valid) n_q <= req_ch.data;
		if (state_q == ST_ADV_DIV)
			prod_q <= {31'd0, PM_A} * {15'd0, gen_q};
		if (log_done) begin
			unique case (state_q)
				ST_LOG_N:  ln_q <= log_res;
				ST_LOG_N1: ln1_q <= log_res;
				ST_LOG_M:  lm_q <= log_res;
				default:   lx_q <= log_res;
			endcase
		end
		if (state_q == ST_ADV_MUL && small_n) cand_q <= 21'd1;
		if (state_q == ST_LOG_X && log_done) begin
			if (num_c[LW] || num_c[LW-1:0] == '0) cand_q <= 21'd1;
			else cand_q <= IVL_MAX;
		end
		if (div_done)
			cand_q <= (quot >= DW'(IVL_MAX)) ? IVL_MAX : IVL_W'(quot + 1'b1);
	end
endmodule
`default_nettype wire
